// File: hw/rtl/dte_pkg.sv
`timescale 1ns / 1ps
package dte_pkg;

	localparam int unsigned ADDR_W = 3;

	localparam logic [7:0] EPOCH_YEAR = 8'd70;
	localparam logic [16:0] DAYS_PER_YEAR = 17'd365;
	localparam logic [3:0] MONTHS_PER_YEAR = 4'd12;
	localparam logic [7:0] LEAP_MONTH = 8'd2;
	localparam logic signed [7:0] ZONE_LIMIT = 8'sd52;
	localparam logic signed [17:0] ZONE_STEP_SEC = 18'sd900;
	localparam logic [31:0] HOURS_PER_DAY = 32'd24;
	localparam logic [31:0] MINUTES_PER_HOUR = 32'd60;
	localparam logic [31:0] SECONDS_PER_MINUTE = 32'd60;

	typedef enum logic [0:0] {
		REG_IGNORE_ZONE = 1'b0,
		REG_NONE = 1'b1
	} dte_reg_t;

	typedef struct packed {
		logic [7:0] year_byte;
		logic [7:0] month;
		logic [7:0] day;
		logic [7:0] hour;
		logic [7:0] minute;
		logic [7:0] second;
		logic signed [7:0] zone_offset;
	} dte_date_t;

	typedef struct packed {
		logic early;
		logic [31:0] days;
		logic [7:0] hour;
		logic [7:0] minute;
		logic [7:0] second;
		logic [31:0] zone_sec;
	} dte_day_t;

	function automatic logic [8:0] cum_days(input logic [3:0] months);
		logic [8:0] d;
		case (months)
			4'd0: d = 9'd0;
			4'd1: d = 9'd31;
			4'd2: d = 9'd59;
			4'd3: d = 9'd90;
			4'd4: d = 9'd120;
			4'd5: d = 9'd151;
			4'd6: d = 9'd181;
			4'd7: d = 9'd212;
			4'd8: d = 9'd243;
			4'd9: d = 9'd273;
			4'd10: d = 9'd304;
			4'd11: d = 9'd334;
			default: d = 9'd365;
		endcase
		return d;
	endfunction

endpackage

// File: hw/rtl/dte_cfg.sv
`timescale 1ns / 1ps
module dte_cfg (
	input logic clk,
	input logic arst_n,
	input logic psel,
	input logic penable,
	input logic pwrite,
	input logic [dte_pkg::ADDR_W-1:0] paddr,
	input logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic pready,
	output logic ignore_zone
);

	logic ignore_zone_q;
	dte_pkg::dte_reg_t reg_sel;

	assign reg_sel = dte_pkg::dte_reg_t'(paddr[dte_pkg::ADDR_W-1]);
	assign pready = 1'b1;
	assign ignore_zone = ignore_zone_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ignore_zone_q <= 1'b0;
		end else if (psel && penable && pwrite && pready && reg_sel == dte_pkg::REG_IGNORE_ZONE) begin
			ignore_zone_q <= pwdata[0];
		end
	end

	always_comb begin
		case (reg_sel)
			dte_pkg::REG_IGNORE_ZONE: prdata = {31'd0, ignore_zone_q};
			default: prdata = 32'd0;
		endcase
	end

endmodule

// File: hw/rtl/dte_day.sv
`timescale 1ns / 1ps
module dte_day (
	input logic clk,
	input logic arst_n,
	input logic vld,
	input dte_pkg::dte_date_t date,
	input logic ignore_zone,
	output logic vld_s1,
	output dte_pkg::dte_day_t day_s1
);

	logic [7:0] yrs;
	logic [8:0] yrs_inc;
	logic [3:0] full_months;
	logic leap;
	logic [16:0] base_days;
	logic zone_used;
	logic signed [17:0] zone_prod;
	dte_pkg::dte_day_t day_c;

	always_comb begin
		yrs = date.year_byte - dte_pkg::EPOCH_YEAR;
		yrs_inc = {1'b0, yrs} + 9'd1;
		if (date.month == 8'd0) begin
			full_months = 4'd0;
		end else if (date.month > {4'd0, dte_pkg::MONTHS_PER_YEAR}) begin
			full_months = dte_pkg::MONTHS_PER_YEAR;
		end else begin
			full_months = 4'(date.month - 8'd1);
		end
		leap = (2'(yrs + 8'd2) == 2'd0) && (date.month > dte_pkg::LEAP_MONTH);
		base_days = 17'(yrs) * dte_pkg::DAYS_PER_YEAR + 17'(yrs_inc >> 2)
			+ 17'(dte_pkg::cum_days(full_months)) + 17'(leap);

		// offsets beyond the limit are dropped
		zone_used = !ignore_zone && (date.zone_offset >= -dte_pkg::ZONE_LIMIT)
			&& (date.zone_offset <= dte_pkg::ZONE_LIMIT);
		zone_prod = 18'(date.zone_offset) * dte_pkg::ZONE_STEP_SEC;

		day_c.early = date.year_byte < dte_pkg::EPOCH_YEAR;
		day_c.days = 32'(base_days) + 32'(date.day) - 32'd1;
		day_c.hour = date.hour;
		day_c.minute = date.minute;
		day_c.second = date.second;
		day_c.zone_sec = zone_used ? 32'(zone_prod) : 32'd0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else begin
			vld_s1 <= vld;
		end
	end

	always_ff @(posedge clk) begin
		if (vld) begin
			day_s1 <= day_c;
		end
	end

endmodule

// File: hw/rtl/dte_time.sv
`timescale 1ns / 1ps
module dte_time (
	input logic clk,
	input logic arst_n,
	input logic vld_s1,
	input dte_pkg::dte_day_t day_s1,
	output logic vld_s4,
	output logic [31:0] secs_s4
);

	logic vld_s2, vld_s3;
	logic early_s2, early_s3;
	logic [31:0] hours_s2, mins_s3;
	logic [7:0] minute_s2;
	logic [7:0] second_s2, second_s3;
	logic [31:0] zone_s2, zone_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
		end else begin
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (vld_s1) begin
			early_s2 <= day_s1.early;
			hours_s2 <= day_s1.days * dte_pkg::HOURS_PER_DAY + 32'(day_s1.hour);
			minute_s2 <= day_s1.minute;
			second_s2 <= day_s1.second;
			zone_s2 <= day_s1.zone_sec;
		end
		if (vld_s2) begin
			early_s3 <= early_s2;
			mins_s3 <= hours_s2 * dte_pkg::MINUTES_PER_HOUR + 32'(minute_s2);
			second_s3 <= second_s2;
			zone_s3 <= zone_s2;
		end
		if (vld_s3) begin
			secs_s4 <= early_s3 ? 32'd0
				: mins_s3 * dte_pkg::SECONDS_PER_MINUTE + 32'(second_s3) - zone_s3;
		end
	end

endmodule

// File: hw/rtl/disc_date_to_epoch_seconds.sv
`timescale 1ns / 1ps
// disc directory date to seconds since 1970
// command channel: a date word is taken at each rising edge with start high
// and busy low; busy never rises, so one word can enter every cycle
// result channel: epoch_seconds is shown for one cycle with done high,
// after the word has passed the day count, hours, minutes and seconds
// stages; throughput one word per cycle, set by the four-stage pipeline
// the receiver cannot stall, so every result is presented exactly once
// years before 1970 give zero; all sums wrap modulo 2^32
// config port: ignore_zone at byte address 0, written with the usual
// setup and access cycles, pready always high, readable
// reset clears ignore_zone and empties the pipeline; words in flight are
// dropped and no done follows for them
module disc_date_to_epoch_seconds (
	input logic clk,
	input logic arst_n,
	input logic start,
	output logic busy,
	input logic [7:0] year_byte,
	input logic [7:0] month,
	input logic [7:0] day,
	input logic [7:0] hour,
	input logic [7:0] minute,
	input logic [7:0] second,
	input logic signed [7:0] zone_offset,
	output logic done,
	output logic signed [31:0] epoch_seconds,
	input logic psel,
	input logic penable,
	input logic pwrite,
	input logic [dte_pkg::ADDR_W-1:0] paddr,
	input logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic pready
);

	logic ignore_zone;
	logic vld_s1;
	logic [31:0] secs_s4;
	dte_pkg::dte_date_t date;
	dte_pkg::dte_day_t day_s1;

	assign busy = 1'b0;
	assign date = '{year_byte: year_byte, month: month, day: day, hour: hour,
		minute: minute, second: second, zone_offset: zone_offset};

	dte_cfg u_cfg (
		.clk(clk),
		.arst_n(arst_n),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready),
		.ignore_zone(ignore_zone)
	);

	dte_day u_day (
		.clk(clk),
		.arst_n(arst_n),
		.vld(start && !busy),
		.date(date),
		.ignore_zone(ignore_zone),
		.vld_s1(vld_s1),
		.day_s1(day_s1)
	);

	dte_time u_time (
		.clk(clk),
		.arst_n(arst_n),
		.vld_s1(vld_s1),
		.day_s1(day_s1),
		.vld_s4(done),
		.secs_s4(secs_s4)
	);

	assign epoch_seconds = $signed(secs_s4);

	a_start_done: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |-> ##4 done)
		else $error("accepted word produced no result");

	a_done_start: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start, 4))
		else $error("result without an accepted word");

	a_early_zero: assert property (@(posedge clk) disable iff (!arst_n)
		done && ($past(year_byte, 4) < dte_pkg::EPOCH_YEAR) |-> epoch_seconds == 32'sd0)
		else $error("year before 1970 gave nonzero seconds");

endmodule

// File: test/tb_top.sv
`timescale 1ns / 1ps
module tb_top;

	localparam int unsigned RESET_CYCLES = 12;
	localparam int unsigned PIPE_DEPTH = 4;
	localparam int unsigned CYCLE_LIMIT = 200000;
	localparam logic [31:0] FIRST_YEAR = 32'd70;
	localparam logic [31:0] YEAR_DAYS = 32'd365;
	localparam int signed ZONE_RANGE = 52;
	localparam int signed ZONE_UNIT_SEC = 900;
	localparam logic [31:0] MONTH_LEN [12] = '{
		32'd31, 32'd28, 32'd31, 32'd30, 32'd31, 32'd30,
		32'd31, 32'd31, 32'd30, 32'd31, 32'd30, 32'd31
	};

	typedef struct packed {
		dte_pkg::dte_date_t date;
		logic typed;
		logic [31:0] value;
	} date_row_t;

	localparam int unsigned N_ROWS = 24;
	localparam date_row_t DATE_TABLE [N_ROWS] = '{
		{8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'h00, 1'b1, 32'd0},
		{8'd69, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'h7F, 1'b1, 32'd0},
		{8'd70, 8'd1, 8'd1, 8'd0, 8'd0, 8'd0, 8'h00, 1'b1, 32'd0},
		{8'd70, 8'd1, 8'd1, 8'd0, 8'd0, 8'd1, 8'h00, 1'b1, 32'd1},
		{8'd70, 8'd1, 8'd2, 8'd0, 8'd0, 8'd0, 8'h00, 1'b1, 32'd86400},
		{8'd70, 8'd1, 8'd0, 8'd0, 8'd0, 8'd0, 8'h00, 1'b1, 32'hFFFE_AE80},
		{8'd70, 8'd1, 8'd1, 8'd0, 8'd0, 8'd0, 8'h04, 1'b1, 32'hFFFF_F1F0},
		{8'd70, 8'd1, 8'd1, 8'd0, 8'd0, 8'd0, 8'hFC, 1'b1, 32'd3600},
		{8'd70, 8'd1, 8'd1, 8'd0, 8'd0, 8'd0, 8'd52, 1'b1, 32'hFFFF_4930},
		{8'd70, 8'd1, 8'd1, 8'd0, 8'd0, 8'd0, 8'd53, 1'b1, 32'd0},
		{8'd70, 8'd1, 8'd1, 8'd0, 8'd0, 8'd0, 8'hCB, 1'b1, 32'd0},
		{8'd70, 8'd1, 8'd1, 8'd0, 8'd0, 8'd0, 8'h80, 1'b1, 32'd0},
		{8'd70, 8'd0, 8'd1, 8'd0, 8'd0, 8'd0, 8'h00, 1'b1, 32'd0},
		{8'd70, 8'd2, 8'd1, 8'd0, 8'd0, 8'd0, 8'h00, 1'b1, 32'd2678400},
		{8'd72, 8'd3, 8'd1, 8'd0, 8'd0, 8'd0, 8'h00, 1'b0, 32'd0},
		{8'd72, 8'd2, 8'd29, 8'd0, 8'd0, 8'd0, 8'h00, 1'b0, 32'd0},
		{8'd70, 8'd12, 8'd31, 8'd23, 8'd59, 8'd59, 8'h00, 1'b0, 32'd0},
		{8'd70, 8'd13, 8'd1, 8'd0, 8'd0, 8'd0, 8'h00, 1'b0, 32'd0},
		{8'd72, 8'd255, 8'd1, 8'd0, 8'd0, 8'd0, 8'h00, 1'b0, 32'd0},
		{8'd200, 8'd3, 8'd1, 8'd0, 8'd0, 8'd0, 8'h00, 1'b0, 32'd0},
		{8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'h7F, 1'b0, 32'd0},
		{8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'hD0, 1'b0, 32'd0},
		{8'd138, 8'd1, 8'd19, 8'd3, 8'd14, 8'd8, 8'h00, 1'b0, 32'd0},
		{8'd70, 8'd1, 8'd1, 8'd255, 8'd255, 8'd255, 8'h00, 1'b0, 32'd0}
	};

	logic clk;
	logic arst_n;
	logic start;
	logic busy;
	logic [7:0] year_byte;
	logic [7:0] month;
	logic [7:0] day;
	logic [7:0] hour;
	logic [7:0] minute;
	logic [7:0] second;
	logic signed [7:0] zone_offset;
	logic done;
	logic signed [31:0] epoch_seconds;
	logic psel;
	logic penable;
	logic pwrite;
	logic [dte_pkg::ADDR_W-1:0] paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic pready;

	logic ignore_zone_model;
	logic [31:0] pending_epochs [$];
	int unsigned error_count;
	int unsigned cycle_count;

	disc_date_to_epoch_seconds dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.year_byte(year_byte),
		.month(month),
		.day(day),
		.hour(hour),
		.minute(minute),
		.second(second),
		.zone_offset(zone_offset),
		.done(done),
		.epoch_seconds(epoch_seconds),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready)
	);

	initial clk = 1'b0;
	always #10 clk = ~clk;

	function automatic logic [31:0] predict_epoch(input dte_pkg::dte_date_t d,
		input logic ign);
		logic [31:0] yrs;
		logic [31:0] days;
		logic [31:0] total;
		int unsigned full_months;
		int signed zone;
		if (d.year_byte < FIRST_YEAR[7:0])
			return 32'd0;
		yrs = 32'(d.year_byte) - FIRST_YEAR;
		days = yrs * YEAR_DAYS + (yrs + 32'd1) / 32'd4;
		full_months = (d.month == 8'd0) ? 0 : int'(d.month) - 1;
		if (full_months > 12)
			full_months = 12;
		for (int m = 0; m < full_months; m++)
			days = days + MONTH_LEN[m];
		if ((yrs + 32'd2) % 32'd4 == 32'd0 && d.month > 8'd2)
			days = days + 32'd1;
		days = days + 32'(d.day) - 32'd1;
		total = ((days * 32'd24 + 32'(d.hour)) * 32'd60 + 32'(d.minute)) * 32'd60
			+ 32'(d.second);
		zone = ign ? 0 : int'($signed(d.zone_offset));
		if (zone >= -ZONE_RANGE && zone <= ZONE_RANGE)
			total = total - 32'(zone * ZONE_UNIT_SEC);
		return total;
	endfunction

	function automatic dte_pkg::dte_date_t random_date();
		dte_pkg::dte_date_t d;
		d = dte_pkg::dte_date_t'(56'({$urandom(), $urandom()}));
		if ($urandom_range(3) != 0) begin
			if ($urandom_range(9) == 0)
				d.year_byte = 8'($urandom_range(69));
			else
				d.year_byte = 8'($urandom_range(255, 70));
			d.month = 8'($urandom_range(12, 1));
			d.day = 8'($urandom_range(31, 1));
			d.hour = 8'($urandom_range(23));
			d.minute = 8'($urandom_range(59));
			d.second = 8'($urandom_range(59));
			d.zone_offset = 8'(int'($urandom_range(2 * ZONE_RANGE)) - ZONE_RANGE);
		end
		return d;
	endfunction

	task automatic put_date(input dte_pkg::dte_date_t d, input logic typed,
		input logic [31:0] value);
		start <= 1'b1;
		year_byte <= d.year_byte;
		month <= d.month;
		day <= d.day;
		hour <= d.hour;
		minute <= d.minute;
		second <= d.second;
		zone_offset <= d.zone_offset;
		do @(posedge clk); while (busy);
		pending_epochs.push_back(typed ? value : predict_epoch(d, ignore_zone_model));
	endtask

	task automatic pause_sender(input int unsigned n);
		start <= 1'b0;
		repeat (n) @(posedge clk);
	endtask

	task automatic drain();
		start <= 1'b0;
		while (pending_epochs.size() != 0)
			@(posedge clk);
		repeat (PIPE_DEPTH + 2) @(posedge clk);
	endtask

	task automatic write_ignore_zone(input logic v);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {dte_pkg::REG_IGNORE_ZONE, 2'b00};
		pwdata <= 32'(v);
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		ignore_zone_model = v;
	endtask

	task automatic walk_table(input logic use_typed);
		for (int i = 0; i < N_ROWS; i++)
			put_date(DATE_TABLE[i].date, use_typed & DATE_TABLE[i].typed,
				DATE_TABLE[i].value);
	endtask

	task automatic run_random(input int unsigned count, input int unsigned idle_pct);
		for (int unsigned i = 0; i < count; i++) begin
			while ($urandom_range(99) < idle_pct)
				pause_sender(1);
			put_date(random_date(), 1'b0, 32'd0);
		end
	endtask

	// result checker
	always @(posedge clk) begin
		if (arst_n && done) begin
			if (pending_epochs.size() == 0) begin
				$error("epoch_seconds: unexpected word, got %0d", epoch_seconds);
				error_count++;
			end else begin
				if (epoch_seconds !== pending_epochs[0]) begin
					$error("epoch_seconds: expected %0d, got %0d",
						$signed(pending_epochs[0]), epoch_seconds);
					error_count++;
				end
				void'(pending_epochs.pop_front());
			end
		end
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("simulation failed");
			$finish;
		end
	end

	initial begin
		ignore_zone_model = 1'b0;
		arst_n <= 1'b0;
		start <= 1'b0;
		year_byte <= 8'd0;
		month <= 8'd0;
		day <= 8'd0;
		hour <= 8'd0;
		minute <= 8'd0;
		second <= 8'd0;
		zone_offset <= 8'sd0;
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= '0;
		pwdata <= 32'd0;
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// zone in use after reset
		walk_table(1'b1);
		drain();
		write_ignore_zone(1'b1);
		walk_table(1'b0);
		drain();

		run_random(600, 6);
		drain();
		write_ignore_zone(1'b0);
		run_random(550, 67);
		drain();
		write_ignore_zone(1'b1);
		run_random(300, 0);
		drain();
		write_ignore_zone(1'b0);
		run_random(250, 0);
		drain();

		if (error_count == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule

// File: sim.f
hw/rtl/dte_pkg.sv
hw/rtl/dte_cfg.sv
hw/rtl/dte_day.sv
hw/rtl/dte_time.sv
hw/rtl/disc_date_to_epoch_seconds.sv
test/tb_top.sv
